// ----- rtl/ecal_pkg.sv -----
// Shared constants, types and month table for the epoch-to-calendar pipeline.
package ecal_pkg;

   localparam int unsigned NumStages = 9;
   localparam int unsigned ReqDataW  = 32;
   localparam int unsigned RspDataW  = 48;

   // days = (seconds >> 7) / 675, exact via ceil(2^35 / 675)
   localparam logic [25:0] DaysRecip    = 26'd50903317;
   localparam logic [9:0]  DayUnits     = 10'd675;
   // hour = (tod >> 4) / 225 via ceil(2^20 / 225)
   localparam logic [12:0] HourRecip    = 13'd4661;
   localparam logic [11:0] HourSecs     = 12'd3600;
   // minute = (rem >> 2) / 15 via ceil(2^16 / 15)
   localparam logic [12:0] MinRecip     = 13'd4370;
   localparam logic [11:0] MinSecs      = 12'd60;
   // weekday quotient via ceil(2^19 / 7)
   localparam logic [16:0] WeekRecip    = 17'd74899;
   localparam logic [15:0] WeekLen      = 16'd7;
   localparam logic [15:0] EpochWeekday = 16'd4;
   // year = y * 400 / 146097 via ceil(400 * 2^40 / 146097)
   localparam logic [31:0] YearRecip    = 32'd3010360590;
   localparam logic [19:0] MarchOffset  = 20'd719468;
   localparam logic [19:0] YearBias     = 20'd2;
   localparam logic [19:0] YearDays     = 20'd365;
   // century = year / 100 via ceil(2^17 / 100)
   localparam logic [10:0] CentRecip    = 11'd1311;
   localparam logic [11:0] CentYears    = 12'd100;
   // month = (yday + 31) * 5 / 153 via ceil(2^18 / 153)
   localparam logic [10:0] MonRecip     = 11'd1714;
   localparam logic [10:0] MonBias      = 11'd31;
   localparam logic [10:0] MonScale     = 11'd5;
   localparam logic [8:0]  JanStart     = 9'd306;
   localparam logic [3:0]  JanShift     = 4'd10;
   localparam logic [3:0]  MarShift     = 4'd2;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } hms_type;

   typedef struct packed {
      logic [2:0]  weekday;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
   } date_type;

   // 367 * mon / 12 - 30 for the March-based month index
   function automatic logic [8:0] month_base(input logic [3:0] mon);
      logic [8:0] base;
      unique case (mon)
         4'd1:    base = 9'd0;
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd61;
         4'd4:    base = 9'd92;
         4'd5:    base = 9'd122;
         4'd6:    base = 9'd153;
         4'd7:    base = 9'd184;
         4'd8:    base = 9'd214;
         4'd9:    base = 9'd245;
         4'd10:   base = 9'd275;
         4'd11:   base = 9'd306;
         4'd12:   base = 9'd337;
         default: base = 9'd0;
      endcase
      return base;
   endfunction

endpackage

// ----- rtl/epoch_seconds_to_calendar.sv -----
// Top level: seconds since 1970-01-01 UTC to broken-down calendar date and time.
// Pipeline: nine register stages, from ecal_days through ecal_tod and ecal_date.
// Throughput: one transaction per cycle while the output is not stalled;
// each stage holds only while the stage after it is full.
// Reset clears the stage valid bits only; no other state is kept.
module epoch_seconds_to_calendar (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ecal_pkg::ReqDataW-1:0]   req_tdata,  // [31:0] epoch_seconds
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [5:0] second, [11:6] minute, [16:12] hour, [21:17] day_of_month,
   // [25:22] month, [37:26] year, [40:38] weekday, [47:41] zero
   output logic [ecal_pkg::RspDataW-1:0]   rsp_tdata
);

   logic [ecal_pkg::NumStages-1:0] v_ff, v_in;
   logic [ecal_pkg::NumStages-1:0] adv;
   logic [15:0]        days;
   logic [16:0]        tod;
   ecal_pkg::hms_type  hms;
   ecal_pkg::date_type date;

   always_comb begin
      adv[ecal_pkg::NumStages-1] = !v_ff[ecal_pkg::NumStages-1] || rsp_tready;
      for (int i = ecal_pkg::NumStages - 2; i >= 0; i--) begin
         adv[i] = !v_ff[i] || adv[i+1];
      end
   end

   assign v_in = {v_ff[ecal_pkg::NumStages-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < ecal_pkg::NumStages; i++) begin
            if (adv[i]) v_ff[i] <= v_in[i];
         end
      end
   end

   ecal_days u_days (
      .clock         (clock),
      .adv           (adv[1:0]),
      .epoch_seconds (req_tdata),
      .days          (days),
      .tod           (tod)
   );

   ecal_tod u_tod (
      .clock (clock),
      .adv   (adv[8:2]),
      .tod   (tod),
      .hms   (hms)
   );

   ecal_date u_date (
      .clock (clock),
      .adv   (adv[8:2]),
      .days  (days),
      .date  (date)
   );

   assign req_tready = adv[0];
   assign rsp_tvalid = v_ff[ecal_pkg::NumStages-1];
   assign rsp_tdata  = {7'b0, date.weekday, date.year, date.month, date.day_of_month,
                        hms.hour, hms.minute, hms.second};

`ifndef ASSERT_OFF
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with an empty output stage");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (hms.hour <= 5'd23 && hms.minute <= 6'd59 && hms.second <= 6'd59))
      else $error("time of day out of range");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (date.month >= 4'd1 && date.month <= 4'd12 &&
                      date.day_of_month >= 5'd1 && date.weekday <= 3'd6))
      else $error("date field out of range");
`endif

endmodule

// ----- rtl/ecal_days.sv -----
// Front stages: split seconds into whole days and seconds of the day.
module ecal_days (
   input  logic        clock,
   input  logic [1:0]  adv,
   input  logic [31:0] epoch_seconds,
   output logic [15:0] days,
   output logic [16:0] tod
);

   logic [24:0] q_ff;
   logic [6:0]  lo_ff;
   logic [50:0] dprod_in, dprod_ff;
   logic [15:0] days_in, days_ff;
   logic [25:0] dmul;
   logic [25:0] qdiff;
   logic [16:0] tod_in, tod_ff;

   assign dprod_in = {26'b0, epoch_seconds[31:7]} * {25'b0, ecal_pkg::DaysRecip};

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         q_ff     <= epoch_seconds[31:7];
         lo_ff    <= epoch_seconds[6:0];
         dprod_ff <= dprod_in;
      end
   end

   assign days_in = dprod_ff[50:35];
   assign dmul    = {10'b0, days_in} * {16'b0, ecal_pkg::DayUnits};
   assign qdiff   = {1'b0, q_ff} - dmul;
   assign tod_in  = {qdiff[9:0], lo_ff};

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         days_ff <= days_in;
         tod_ff  <= tod_in;
      end
   end

   assign days = days_ff;
   assign tod  = tod_ff;

endmodule

// ----- rtl/ecal_tod.sv -----
// Time-of-day stages: hour, minute and second from seconds of the day.
module ecal_tod (
   input  logic              clock,
   input  logic [8:2]        adv,
   input  logic [16:0]       tod,
   output ecal_pkg::hms_type hms
);

   logic [16:0] tod2_ff;
   logic [25:0] hprod_in, hprod_ff;
   logic [4:0]  hour_in, hour3_ff, hour4_ff;
   logic [16:0] hsec;
   logic [16:0] hdiff;
   logic [11:0] rem_in, rem3_ff, rem4_ff;
   logic [22:0] mprod_in, mprod_ff;
   logic [5:0]  min_in;
   logic [11:0] msec;
   logic [11:0] mdiff;
   ecal_pkg::hms_type hms_in, hms5_ff, hms6_ff, hms7_ff, hms8_ff;

   assign hprod_in = {13'b0, tod[16:4]} * {13'b0, ecal_pkg::HourRecip};

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         tod2_ff  <= tod;
         hprod_ff <= hprod_in;
      end
   end

   assign hour_in = hprod_ff[24:20];
   assign hsec    = {12'b0, hour_in} * {5'b0, ecal_pkg::HourSecs};
   assign hdiff   = tod2_ff - hsec;
   assign rem_in  = hdiff[11:0];

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         hour3_ff <= hour_in;
         rem3_ff  <= rem_in;
      end
   end

   assign mprod_in = {13'b0, rem3_ff[11:2]} * {10'b0, ecal_pkg::MinRecip};

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         hour4_ff <= hour3_ff;
         rem4_ff  <= rem3_ff;
         mprod_ff <= mprod_in;
      end
   end

   assign min_in = mprod_ff[21:16];
   assign msec   = {6'b0, min_in} * ecal_pkg::MinSecs;
   assign mdiff  = rem4_ff - msec;

   always_comb begin
      hms_in.hour   = hour4_ff;
      hms_in.minute = min_in;
      hms_in.second = mdiff[5:0];
   end

   always_ff @(posedge clock) begin
      if (adv[5]) hms5_ff <= hms_in;
      if (adv[6]) hms6_ff <= hms5_ff;
      if (adv[7]) hms7_ff <= hms6_ff;
      if (adv[8]) hms8_ff <= hms7_ff;
   end

   assign hms = hms8_ff;

endmodule

// ----- rtl/ecal_date.sv -----
// Date stages: year, month, day of month and weekday from the day count.
module ecal_date (
   input  logic               clock,
   input  logic [8:2]         adv,
   input  logic [15:0]        days,
   output ecal_pkg::date_type date
);

   logic [19:0] mdays_in, mdays2_ff, mdays3_ff;
   logic [19:0] ybias;
   logic [51:0] yprod_in, yprod_ff;
   logic [15:0] x_in, x2_ff;
   logic [32:0] wprod_in, wprod_ff;
   logic [11:0] year_in, year3_ff;
   logic [15:0] wmul;
   logic [15:0] wdiff;
   logic [2:0]  wday3_ff, wday4_ff, wday5_ff, wday6_ff, wday7_ff;
   logic [22:0] cprod_in, cprod_ff;
   logic [4:0]  cent;
   logic [19:0] y365;
   logic [19:0] base;
   logic [20:0] ydw;
   logic [11:0] c100;
   logic [11:0] ymod;
   logic        leap_in, leap4_ff;
   logic [10:0] yday4_ff;
   logic [11:0] year4_ff;
   logic [10:0] ysum;
   logic [8:0]  yc_in, yc5_ff, yc6_ff;
   logic [11:0] year5_in, year5_ff, year6_ff, year7_ff;
   logic [10:0] xm_in, xm5_ff;
   logic [21:0] mprod_in, mprod_ff;
   logic [3:0]  mon_in, mon7_ff;
   logic [8:0]  mday_wide;
   logic        jan_in, jan7_ff;
   logic [4:0]  mday7_ff;
   ecal_pkg::date_type date_in, date_ff;

   // S2: rebase to 1 March 1 BC, year and weekday products
   assign mdays_in = {4'b0, days} + ecal_pkg::MarchOffset;
   assign ybias    = mdays_in + ecal_pkg::YearBias;
   assign yprod_in = {32'b0, ybias} * {20'b0, ecal_pkg::YearRecip};
   assign x_in     = days + ecal_pkg::EpochWeekday;
   assign wprod_in = {17'b0, x_in} * {16'b0, ecal_pkg::WeekRecip};

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         mdays2_ff <= mdays_in;
         yprod_ff  <= yprod_in;
         x2_ff     <= x_in;
         wprod_ff  <= wprod_in;
      end
   end

   // S3: year estimate, weekday, century product
   assign year_in  = yprod_ff[51:40];
   assign wmul     = {3'b0, wprod_ff[31:19]} * ecal_pkg::WeekLen;
   assign wdiff    = x2_ff - wmul;
   assign cprod_in = {11'b0, year_in} * {12'b0, ecal_pkg::CentRecip};

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         mdays3_ff <= mdays2_ff;
         year3_ff  <= year_in;
         wday3_ff  <= wdiff[2:0];
         cprod_ff  <= cprod_in;
      end
   end

   // S4: day of year against the estimated year, leap flag
   assign cent  = cprod_ff[21:17];
   assign y365  = {8'b0, year3_ff} * ecal_pkg::YearDays;
   assign base  = y365 + {10'b0, year3_ff[11:2]} - {15'b0, cent} + {17'b0, cent[4:2]};
   assign ydw   = {1'b0, mdays3_ff} - {1'b0, base};
   assign c100  = {7'b0, cent} * ecal_pkg::CentYears;
   assign ymod  = year3_ff - c100;
   assign leap_in = (year3_ff[1:0] == 2'b00) && ((ymod[6:0] != 7'd0) || (cent[1:0] == 2'b00));

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         yday4_ff <= ydw[10:0];
         year4_ff <= year3_ff;
         leap4_ff <= leap_in;
         wday4_ff <= wday3_ff;
      end
   end

   // S5: fix an overshooting year estimate
   assign ysum = yday4_ff + 11'd365 + {10'b0, leap4_ff};

   always_comb begin
      if (yday4_ff[10]) begin
         yc_in     = ysum[8:0];
         year5_in  = year4_ff - 12'd1;
      end else begin
         yc_in     = yday4_ff[8:0];
         year5_in  = year4_ff;
      end
   end

   assign xm_in = ({2'b0, yc_in} + ecal_pkg::MonBias) * ecal_pkg::MonScale;

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         yc5_ff   <= yc_in;
         year5_ff <= year5_in;
         xm5_ff   <= xm_in;
         wday5_ff <= wday4_ff;
      end
   end

   // S6: month product
   assign mprod_in = {11'b0, xm5_ff} * {11'b0, ecal_pkg::MonRecip};

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         yc6_ff   <= yc5_ff;
         year6_ff <= year5_ff;
         mprod_ff <= mprod_in;
         wday6_ff <= wday5_ff;
      end
   end

   // S7: March-based month and day of month
   assign mon_in    = mprod_ff[21:18];
   assign mday_wide = yc6_ff - ecal_pkg::month_base(mon_in) + 9'd1;
   assign jan_in    = (yc6_ff >= ecal_pkg::JanStart);

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         mon7_ff  <= mon_in;
         mday7_ff <= mday_wide[4:0];
         jan7_ff  <= jan_in;
         year7_ff <= year6_ff;
         wday7_ff <= wday6_ff;
      end
   end

   // S8: January and February belong to the next year
   always_comb begin
      date_in.weekday      = wday7_ff;
      date_in.day_of_month = mday7_ff;
      if (jan7_ff) begin
         date_in.year  = year7_ff + 12'd1;
         date_in.month = mon7_ff - ecal_pkg::JanShift;
      end else begin
         date_in.year  = year7_ff;
         date_in.month = mon7_ff + ecal_pkg::MarShift;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[8]) date_ff <= date_in;
   end

   assign date = date_ff;

endmodule
